// File: hw/rtl/mbiq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbiq_pkg: shared types and constants of the multichannel biquad filter
// Channel count, filter order, field widths, command and register codes, and
// the structs passed between the coefficient bank, history store and MAC.
// ----------------------------------------------------------------------------
package mbiq_pkg;

  localparam int CHANNELS = 8;  // 1 .. 8
  localparam int ORDER    = 2;  // 1 .. 2

  localparam int CH_W     = 3;   // channel field width
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMD_W    = 2;
  localparam int SMP_W    = 24;  // Q1.23 samples
  localparam int COEF_W   = 32;  // Q4.28 gains
  localparam int FRAC_W   = 28;  // coefficient fraction bits
  localparam int PROD_W   = COEF_W + SMP_W;
  localparam int ACC_W    = PROD_W + 3;  // five products
  localparam int CFG_IDX_W = 3;

  localparam logic signed [COEF_W-1:0] FF_GAIN0_RST = 32'sh1000_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILTER  = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF_GAIN0 = 3'd0,
    REG_FF_GAIN1 = 3'd1,
    REG_FF_GAIN2 = 3'd2,
    REG_FB_GAIN1 = 3'd3,
    REG_FB_GAIN2 = 3'd4
  } reg_idx_t;

  typedef enum logic {
    HOP_SHIFT = 1'b0,
    HOP_CLEAR = 1'b1
  } hist_op_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] ff_gain0;
    logic signed [COEF_W-1:0] ff_gain1;
    logic signed [COEF_W-1:0] ff_gain2;
    logic signed [COEF_W-1:0] fb_gain1;
    logic signed [COEF_W-1:0] fb_gain2;
  } coef_t;

  typedef struct packed {
    logic [ORDER-1:0][SMP_W-1:0] x;
    logic [ORDER-1:0][SMP_W-1:0] y;
  } hist_taps_t;

  typedef struct packed {
    logic                vld;
    hist_op_t            op;
    logic [CH_IDX_W-1:0] ch;
    logic [SMP_W-1:0]    x;
    logic [SMP_W-1:0]    y;
  } hist_upd_t;

endpackage

// File: hw/rtl/multichannel_biquad_iir_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_biquad_iir_filter_core: multichannel direct-form-I biquad
// Time-multiplexed second-order IIR section with separate input and output
// history per channel, programmable Q4.28 gains, rounded and saturated output.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake              Payload
//   -------  ---------------------  --------------------------------------
//   in       in_valid / in_ready    in_cmd, in_channel, in_sample_in
//   out      out_valid / out_ready  out_sample_out, out_channel_out,
//                                   out_saturated
//   cfg      cfg_wr_en              cfg_index, cfg_data
//
// One item per clock sustained, any mix of channels and commands, as long as
// the consumer takes each result. A filter command waits in the input stage,
// then the combinational MAC loads the result register, from which the output
// transfer takes place.
// The MAC and history update complete within the input stage, so the next
// sample of the same channel sees the new history without a stall.
// Reset (synchronous, rst_n low) restores the default gains and zeroes all
// history together; no clearing pass.
// A stalled result holds the input stage only for filter commands; advance,
// clear and ignored commands drain past a waiting result.
// ----------------------------------------------------------------------------
module multichannel_biquad_iir_filter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mbiq_pkg::CMD_W-1:0]          in_cmd,
  input  logic [mbiq_pkg::CH_W-1:0]           in_channel,
  input  logic signed [mbiq_pkg::SMP_W-1:0]   in_sample_in,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mbiq_pkg::SMP_W-1:0]   out_sample_out,
  output logic [mbiq_pkg::CH_W-1:0]           out_channel_out,
  output logic                                out_saturated,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [mbiq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbiq_pkg::COEF_W-1:0]         cfg_data
);

  // input stage
  logic                               in_vld_r, in_vld_nxt;
  logic [mbiq_pkg::CMD_W-1:0]         cmd_r;
  logic [mbiq_pkg::CH_W-1:0]          ch_r;
  logic signed [mbiq_pkg::SMP_W-1:0]  smp_r;

  // result register
  logic                               out_vld_r, out_vld_nxt;
  logic signed [mbiq_pkg::SMP_W-1:0]  out_smp_r;
  logic [mbiq_pkg::CH_W-1:0]          out_ch_r;
  logic                               out_sat_r;

  logic                               ch_ok;
  logic                               is_filter, is_adv, is_clr;
  logic                               out_free;
  logic                               fire;
  logic [mbiq_pkg::CH_IDX_W-1:0]      ch_idx;

  mbiq_pkg::coef_t                    coef;
  mbiq_pkg::hist_taps_t               taps;
  mbiq_pkg::hist_upd_t                upd;
  logic signed [mbiq_pkg::SMP_W-1:0]  mac_y;
  logic                               mac_sat;

  // ---- command decode for the item held in the input stage ----
  assign ch_ok  = (32'(ch_r) < mbiq_pkg::CHANNELS);
  assign ch_idx = mbiq_pkg::CH_IDX_W'(ch_r);

  always_comb begin
    is_filter = 1'b0;
    is_adv    = 1'b0;
    is_clr    = 1'b0;
    unique case (mbiq_pkg::cmd_t'(cmd_r))
      mbiq_pkg::CMD_FILTER:  is_filter = ch_ok;
      mbiq_pkg::CMD_ADVANCE: is_adv    = ch_ok;
      mbiq_pkg::CMD_CLEAR:   is_clr    = 1'b1;
      default: ;  // unused code: drop the item
    endcase
  end

  // ---- flow control ----
  // The result slot is free when empty or being taken this cycle. Only a
  // filter command needs it; everything else retires unconditionally.
  assign out_free = !out_vld_r || out_ready;
  assign fire     = in_vld_r && (!is_filter || out_free);
  assign in_ready = !in_vld_r || fire;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // capture the payload on every input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
      ch_r  <= in_channel;
      smp_r <= in_sample_in;
    end
  end

  // ---- coefficients, history and MAC ----
  mbiq_coef_regs u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Update the taps at retirement: shift in the sample and the saturated output
  // for a filter command, zeros for an advance; a clear zeroes every channel.
  always_comb begin
    upd.vld = fire && (is_filter || is_adv || is_clr);
    upd.op  = is_clr ? mbiq_pkg::HOP_CLEAR : mbiq_pkg::HOP_SHIFT;
    upd.ch  = ch_idx;
    upd.x   = is_filter ? smp_r : '0;
    upd.y   = is_filter ? mac_y : '0;
  end

  mbiq_history u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_ch (ch_idx),
    .taps  (taps),
    .upd   (upd)
  );

  mbiq_mac u_mac (
    .coef      (coef),
    .taps      (taps),
    .sample    (smp_r),
    .result    (mac_y),
    .saturated (mac_sat)
  );

  // ---- result register ----
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (fire && is_filter) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // load a new result; hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (fire && is_filter) begin
      out_smp_r <= mac_y;
      out_ch_r  <= ch_r;
      out_sat_r <= mac_sat;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_sample_out  = out_smp_r;
  assign out_channel_out = out_ch_r;
  assign out_saturated   = out_sat_r;

`ifndef NO_ASSERTIONS
  // a retiring filter command always lands in the result register
  a_filter_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_filter |=> out_vld_r)
    else $error("filter command retired without a result");

  // a filter command blocked by a full result slot stays in the input stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && is_filter && !out_free |=> in_vld_r && $stable(cmd_r) && $stable(ch_r)
      && $stable(smp_r))
    else $error("stalled filter command lost");

  // non-filter commands never disturb a waiting result
  a_bypass_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !is_filter && out_vld_r && !out_ready |=> out_vld_r && $stable(out_smp_r)
      && $stable(out_ch_r) && $stable(out_sat_r))
    else $error("waiting result changed by a non-filter command");

  // a clear leaves every channel's taps at zero
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_clr |=> taps == '0)
    else $error("history not zero after clear");

  // a flagged result sits at one of the two clip levels
  a_sat_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_sat_r |-> out_smp_r == {1'b0, {(mbiq_pkg::SMP_W-1){1'b1}}}
      || out_smp_r == {1'b1, {(mbiq_pkg::SMP_W-1){1'b0}}})
    else $error("saturation flag without a clipped value");
`endif

endmodule

// File: hw/rtl/mbiq_coef_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbiq_coef_regs: coefficient register bank
// Holds the three feedforward and two feedback gains, written by index.
// ----------------------------------------------------------------------------
module mbiq_coef_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [mbiq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbiq_pkg::COEF_W-1:0]          cfg_data,
  output mbiq_pkg::coef_t                      coef
);

  mbiq_pkg::coef_t coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.ff_gain0 <= mbiq_pkg::FF_GAIN0_RST;
      coef_r.ff_gain1 <= '0;
      coef_r.ff_gain2 <= '0;
      coef_r.fb_gain1 <= '0;
      coef_r.fb_gain2 <= '0;
    end else if (cfg_wr_en) begin
      // drop writes beyond the register list
      unique case (mbiq_pkg::reg_idx_t'(cfg_index))
        mbiq_pkg::REG_FF_GAIN0: coef_r.ff_gain0 <= cfg_data;
        mbiq_pkg::REG_FF_GAIN1: coef_r.ff_gain1 <= cfg_data;
        mbiq_pkg::REG_FF_GAIN2: coef_r.ff_gain2 <= cfg_data;
        mbiq_pkg::REG_FB_GAIN1: coef_r.fb_gain1 <= cfg_data;
        mbiq_pkg::REG_FB_GAIN2: coef_r.fb_gain2 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coef = coef_r;

endmodule

// File: hw/rtl/mbiq_history.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbiq_history: per-channel input and output history taps
// Reads the taps of one channel; shifts one channel or clears all channels.
// ----------------------------------------------------------------------------
module mbiq_history (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mbiq_pkg::CH_IDX_W-1:0]   rd_ch,
  output mbiq_pkg::hist_taps_t            taps,
  input  mbiq_pkg::hist_upd_t             upd
);

  logic [mbiq_pkg::ORDER-1:0][mbiq_pkg::SMP_W-1:0] xh_r [mbiq_pkg::CHANNELS];
  logic [mbiq_pkg::ORDER-1:0][mbiq_pkg::SMP_W-1:0] yh_r [mbiq_pkg::CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < mbiq_pkg::CHANNELS; c++) begin
        xh_r[c] <= '0;
        yh_r[c] <= '0;
      end
    end else if (upd.vld) begin
      unique case (upd.op)
        mbiq_pkg::HOP_CLEAR: begin
          for (int c = 0; c < mbiq_pkg::CHANNELS; c++) begin
            xh_r[c] <= '0;
            yh_r[c] <= '0;
          end
        end
        mbiq_pkg::HOP_SHIFT: begin
          // age the taps, newest value enters tap 0
          for (int t = mbiq_pkg::ORDER - 1; t > 0; t--) begin
            xh_r[upd.ch][t] <= xh_r[upd.ch][t-1];
            yh_r[upd.ch][t] <= yh_r[upd.ch][t-1];
          end
          xh_r[upd.ch][0] <= upd.x;
          yh_r[upd.ch][0] <= upd.y;
        end
        default: ;
      endcase
    end
  end

  assign taps.x = xh_r[rd_ch];
  assign taps.y = yh_r[rd_ch];

endmodule

// File: hw/rtl/mbiq_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbiq_mac: biquad multiply-accumulate, rounding and saturation
// Five parallel Q4.28 x Q1.23 products, summed, rounded to nearest and
// clipped back to a 24-bit Q1.23 sample.
// ----------------------------------------------------------------------------
module mbiq_mac (
  input  mbiq_pkg::coef_t                       coef,
  input  mbiq_pkg::hist_taps_t                  taps,
  input  logic signed [mbiq_pkg::SMP_W-1:0]     sample,
  output logic signed [mbiq_pkg::SMP_W-1:0]     result,
  output logic                                  saturated
);

  localparam int QW = mbiq_pkg::ACC_W - mbiq_pkg::FRAC_W;

  logic signed [mbiq_pkg::PROD_W-1:0] p_x0, p_x1, p_x2, p_y1, p_y2;
  logic signed [mbiq_pkg::ACC_W-1:0]  acc;
  logic signed [mbiq_pkg::ACC_W-1:0]  acc_rnd;
  logic signed [QW-1:0]               q;
  logic                               sat_hi, sat_lo;

  assign p_x0 = coef.ff_gain0 * sample;
  assign p_x1 = coef.ff_gain1 * $signed(taps.x[0]);
  assign p_y1 = coef.fb_gain1 * $signed(taps.y[0]);

  // second taps only exist for a second-order section
  always_comb begin
    p_x2 = '0;
    p_y2 = '0;
    if (mbiq_pkg::ORDER >= 2) begin
      p_x2 = coef.ff_gain2 * $signed(taps.x[mbiq_pkg::ORDER-1]);
      p_y2 = coef.fb_gain2 * $signed(taps.y[mbiq_pkg::ORDER-1]);
    end
  end

  assign acc = mbiq_pkg::ACC_W'(p_x0) + mbiq_pkg::ACC_W'(p_x1) + mbiq_pkg::ACC_W'(p_x2)
             + mbiq_pkg::ACC_W'(p_y1) + mbiq_pkg::ACC_W'(p_y2);

  // round half up, then floor-shift back to Q1.23
  assign acc_rnd = acc + $signed({{(mbiq_pkg::ACC_W - mbiq_pkg::FRAC_W){1'b0}}, 1'b1,
                                  {(mbiq_pkg::FRAC_W - 1){1'b0}}});
  assign q = acc_rnd[mbiq_pkg::ACC_W-1:mbiq_pkg::FRAC_W];

  assign sat_hi = !q[QW-1] && (|q[QW-2:mbiq_pkg::SMP_W-1]);
  assign sat_lo =  q[QW-1] && !(&q[QW-2:mbiq_pkg::SMP_W-1]);

  always_comb begin
    priority if (sat_hi) begin
      result = {1'b0, {(mbiq_pkg::SMP_W-1){1'b1}}};
    end else if (sat_lo) begin
      result = {1'b1, {(mbiq_pkg::SMP_W-1){1'b0}}};
    end else begin
      result = q[mbiq_pkg::SMP_W-1:0];
    end
  end

  assign saturated = sat_hi || sat_lo;

endmodule
